// File: rtl/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
// Holds request and status codes, the controller state and datapath command/status structs.
// No dependencies.
package vna_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TRI  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NOP  = 2'd3
  } req_t;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_ZERO_LEN = 2'd2;

  localparam int FRAC_BITS  = 14;   // Q1.14 output scale
  localparam int MAG_BITS   = 30;   // magnitudes are scaled below 2^30
  localparam int SQ_BITS    = 62;
  localparam int ROOT_BITS  = 31;
  localparam int REM_BITS   = 46;
  localparam int DIV_STEPS  = 15;
  localparam logic [14:0] Q_ONE = 15'd16384;

  localparam logic [5:0] MUL_LAST  = 6'd5;
  localparam logic [5:0] SQ_LAST   = 6'd2;
  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd14;
  localparam logic [1:0] IDX_LAST  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_LOAD, ST_VRD, ST_DIFF, ST_MUL, ST_SRD, ST_SACC,
    ST_MAG, ST_CHK, ST_SHIFT, ST_SQ, ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT,
    ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD, OP_VRD, OP_DIFF, OP_MUL, OP_SRD, OP_SACC,
    OP_MAG, OP_ZERO, OP_SHIFT, OP_SQ, OP_SQRT_INIT, OP_SQRT, OP_DIV_INIT,
    OP_DIV
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
    logic cnt_clr;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    req_t       req;
    logic       range_err;
    logic       acc_zero;
    logic       mag_big;
    logic       out_free;
    logic [5:0] cnt;
    logic [1:0] idx;
  } sts_t;

endpackage

// File: rtl/vna_ifs.sv
// Channel interfaces for the vertex normal accumulator: request, result and config.
// Payload widths are fixed by the item formats. No dependencies.
interface vna_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  req_type;
  logic        [9:0]  vertex_slot;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic        [9:0]  corner_a;
  logic        [9:0]  corner_b;
  logic        [9:0]  corner_c;
  modport source (output valid, req_type, vertex_slot, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, req_type, vertex_slot, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic        [1:0]  status;
  modport source (output valid, normal_x, normal_y, normal_z, status, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, status, output ready);
endinterface

interface vna_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

// File: rtl/vna_ctrl.sv
// Sequencing state machine for the vertex normal accumulator.
// Depends on vna_pkg; drives datapath commands from its status.
module vna_ctrl import vna_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (sts.range_err) state_nxt = ST_DONE;
        else begin
          unique case (sts.req)
            REQ_LOAD: state_nxt = ST_LOAD;
            REQ_TRI:  state_nxt = ST_VRD;
            REQ_READ: state_nxt = ST_SRD;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LOAD:      state_nxt = ST_DONE;
      ST_VRD:       if (sts.idx == IDX_LAST) state_nxt = ST_DIFF;
      ST_DIFF:      state_nxt = ST_MUL;
      ST_MUL:       if (sts.cnt == MUL_LAST) state_nxt = ST_SRD;
      ST_SRD:       state_nxt = (sts.req == REQ_TRI) ? ST_SACC : ST_MAG;
      ST_SACC:      state_nxt = (sts.idx == IDX_LAST) ? ST_DONE : ST_SRD;
      ST_MAG:       state_nxt = ST_CHK;
      ST_CHK:       state_nxt = sts.acc_zero ? ST_DONE : ST_SHIFT;
      ST_SHIFT:     if (!sts.mag_big) state_nxt = ST_SQ;
      ST_SQ:        if (sts.cnt == SQ_LAST) state_nxt = ST_SQRT_INIT;
      ST_SQRT_INIT: state_nxt = ST_SQRT;
      ST_SQRT:      if (sts.cnt == SQRT_LAST) state_nxt = ST_DIV_INIT;
      ST_DIV_INIT:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.cnt == DIV_LAST)
          state_nxt = (sts.idx == IDX_LAST) ? ST_DONE : ST_DIV_INIT;
      end
      ST_DONE:      if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.cnt_clr  = (state_nxt != state_r);
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_CAPTURE;
      end
      ST_DECODE:    cmd.idx_clr = 1'b1;
      ST_LOAD:      cmd.op = OP_LOAD;
      ST_VRD: begin
        cmd.op      = OP_VRD;
        cmd.idx_inc = 1'b1;
      end
      ST_DIFF: begin
        cmd.op      = OP_DIFF;
        cmd.idx_clr = 1'b1;
      end
      ST_MUL:       cmd.op = OP_MUL;
      ST_SRD:       cmd.op = OP_SRD;
      ST_SACC: begin
        cmd.op      = OP_SACC;
        cmd.idx_inc = 1'b1;
      end
      ST_MAG:       cmd.op = OP_MAG;
      ST_CHK:       if (sts.acc_zero) cmd.op = OP_ZERO;
      ST_SHIFT:     if (sts.mag_big) cmd.op = OP_SHIFT;
      ST_SQ:        cmd.op = OP_SQ;
      ST_SQRT_INIT: begin
        cmd.op      = OP_SQRT_INIT;
        cmd.idx_clr = 1'b1;
      end
      ST_SQRT:      cmd.op = OP_SQRT;
      ST_DIV_INIT:  cmd.op = OP_DIV_INIT;
      ST_DIV: begin
        cmd.op      = OP_DIV;
        cmd.idx_inc = (sts.cnt == DIV_LAST);
      end
      ST_DONE:      cmd.out_load = sts.out_free;
      default:      cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/vna_datapath.sv
// Datapath of the vertex normal accumulator: vertex and sum memories, cross product,
// saturating accumulate, and the iterative square root and divide. Depends on vna_pkg.
module vna_datapath import vna_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  parameter int SUM_BITS     = 44
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic        [1:0]  in_req_type,
  input  logic        [9:0]  in_vertex_slot,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic        [9:0]  in_corner_a,
  input  logic        [9:0]  in_corner_b,
  input  logic        [9:0]  in_corner_c,
  input  logic               cfg_we,
  input  logic        [10:0] cfg_vertex_count,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic        [1:0]  out_status
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int NB = PW + 1;
  localparam int SB = SUM_BITS;
  localparam int EW = ((SB > NB) ? SB : NB) + 1;
  localparam logic signed [EW-1:0] SUM_HI = {{(EW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [EW-1:0] SUM_LO = ~SUM_HI;

  // memories
  logic [3*CB-1:0] vmem [MAX_VERTICES];
  logic [3*SB-1:0] smem [MAX_VERTICES];
  logic [3*CB-1:0] vrd_r;
  logic [3*SB-1:0] srd_r;

  logic [10:0]     vcount_r;
  req_t            req_r;
  logic [9:0]      slot_r, ca_r, cb_r, cc_r;
  logic [CB-1:0]   px_r, py_r, pz_r;
  logic            range_err_r;
  logic [5:0]      cnt_r;
  logic [1:0]      idx_r;
  logic [3*CB-1:0] va_r, vb_r;
  logic signed [DW-1:0] ux_r, uy_r, uz_r, wx_r, wy_r, wz_r;
  logic signed [NB-1:0] nx_r, ny_r, nz_r;
  logic [SB-1:0]   mag_r [3];
  logic [2:0]      sgn_r;
  logic [SQ_BITS-1:0] sq_r;
  logic [63:0]     sn_r, sr_r, sb_r;
  logic [REM_BITS-1:0] rem_r;
  logic [14:0]     q_r;
  logic [15:0]     res_n_r [3];
  logic [1:0]      res_st_r;
  logic            out_valid_r;
  logic [15:0]     out_n_r [3];
  logic [1:0]      out_st_r;

  function automatic logic slot_ok(input logic [9:0] s, input logic [10:0] vc);
    return ({1'b0, s} < vc) && (32'(s) < 32'(MAX_VERTICES));
  endfunction

  function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] s,
                                            input logic signed [NB-1:0] d);
    logic signed [EW-1:0] t;
    t = $signed({{(EW-SB){s[SB-1]}}, s}) + $signed({{(EW-NB){d[NB-1]}}, d});
    if (t > SUM_HI)      t = SUM_HI;
    else if (t < SUM_LO) t = SUM_LO;
    return t[SB-1:0];
  endfunction

  function automatic logic signed [DW-1:0] ext(input logic [CB-1:0] v);
    return $signed({v[CB-1], v});
  endfunction

  // request range check
  logic range_err_c;
  always_comb begin
    unique case (req_t'(in_req_type))
      REQ_LOAD, REQ_READ: range_err_c = !slot_ok(in_vertex_slot, vcount_r);
      REQ_TRI: range_err_c = !slot_ok(in_corner_a, vcount_r) ||
                             !slot_ok(in_corner_b, vcount_r) ||
                             !slot_ok(in_corner_c, vcount_r);
      default: range_err_c = 1'b0;
    endcase
  end

  // addressing
  logic [9:0]    corner_sel;
  logic [AW-1:0] vaddr, saddr;
  always_comb begin
    case (idx_r)
      2'd0:    corner_sel = ca_r;
      2'd1:    corner_sel = cb_r;
      default: corner_sel = cc_r;
    endcase
    vaddr = AW'(corner_sel);
    saddr = (req_r == REQ_TRI) ? AW'(corner_sel) : AW'(slot_r);
  end

  // accumulate write data
  logic [3*SB-1:0] swdata;
  always_comb begin
    if (cmd.op == OP_LOAD) swdata = '0;
    else swdata = {sat_add(srd_r[3*SB-1:2*SB], nx_r),
                   sat_add(srd_r[2*SB-1:SB], ny_r),
                   sat_add(srd_r[SB-1:0], nz_r)};
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) vmem[AW'(slot_r)] <= {px_r, py_r, pz_r};
    vrd_r <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD || cmd.op == OP_SACC) smem[saddr] <= swdata;
    srd_r <= smem[saddr];
  end

  // shared cross-product multiplier
  logic signed [DW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [NB-1:0] prod_e;
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin ma = uy_r; mb = wz_r; end
      3'd1:    begin ma = uz_r; mb = wy_r; end
      3'd2:    begin ma = uz_r; mb = wx_r; end
      3'd3:    begin ma = ux_r; mb = wz_r; end
      3'd4:    begin ma = ux_r; mb = wy_r; end
      default: begin ma = uy_r; mb = wx_r; end
    endcase
    prod   = ma * mb;
    prod_e = $signed({prod[PW-1], prod});
  end

  // magnitudes of the sums
  logic [SB-1:0] sum_c [3];
  always_comb begin
    sum_c[0] = srd_r[3*SB-1:2*SB];
    sum_c[1] = srd_r[2*SB-1:SB];
    sum_c[2] = srd_r[SB-1:0];
  end

  logic acc_zero_c, mag_big_c;
  always_comb begin
    acc_zero_c = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
    mag_big_c  = (mag_r[0][SB-1:MAG_BITS] != '0) || (mag_r[1][SB-1:MAG_BITS] != '0) ||
                 (mag_r[2][SB-1:MAG_BITS] != '0);
  end

  // square accumulate
  logic [MAG_BITS-1:0] sq_in;
  logic [2*MAG_BITS-1:0] sq_p;
  always_comb begin
    sq_in = mag_r[cnt_r[1:0]][MAG_BITS-1:0];
    sq_p  = sq_in * sq_in;
  end

  // square root step
  logic [63:0] sq_t;
  logic        sq_ge;
  always_comb begin
    sq_t  = sr_r + sb_r;
    sq_ge = (sn_r >= sq_t);
  end

  // divide step
  logic [ROOT_BITS-1:0] len;
  logic [3:0]           sh;
  logic [REM_BITS-1:0]  dv;
  logic                 dv_ge;
  logic [14:0]          q_nxt, q_cl;
  logic [15:0]          q_sgn;
  always_comb begin
    len   = (sr_r[ROOT_BITS-1:0] == '0) ? ROOT_BITS'(1) : sr_r[ROOT_BITS-1:0];
    sh    = 4'(DIV_STEPS - 1) - cnt_r[3:0];
    dv    = REM_BITS'(len) << sh;
    dv_ge = (rem_r >= dv);
    q_nxt = dv_ge ? (q_r | (15'd1 << sh)) : q_r;
    q_cl  = (q_nxt > Q_ONE) ? Q_ONE : q_nxt;
    q_sgn = sgn_r[idx_r] ? (16'd0 - {1'b0, q_cl}) : {1'b0, q_cl};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= 11'd1024;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (cfg_we) vcount_r <= cfg_vertex_count;
      if (cmd.out_load)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      cnt_r <= cmd.cnt_clr ? 6'd0 : cnt_r + 6'd1;
      if (cmd.idx_clr)      idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 2'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_n_r  <= res_n_r;
      out_st_r <= res_st_r;
    end
    case (cmd.op)
      OP_CAPTURE: begin
        req_r       <= req_t'(in_req_type);
        slot_r      <= in_vertex_slot;
        px_r        <= CB'($unsigned(in_pos_x));
        py_r        <= CB'($unsigned(in_pos_y));
        pz_r        <= CB'($unsigned(in_pos_z));
        ca_r        <= in_corner_a;
        cb_r        <= in_corner_b;
        cc_r        <= in_corner_c;
        range_err_r <= range_err_c;
        res_n_r     <= '{default: '0};
        res_st_r    <= range_err_c ? STAT_RANGE : STAT_OK;
      end
      OP_VRD: begin
        if (idx_r == 2'd1) va_r <= vrd_r;
        if (idx_r == 2'd2) vb_r <= vrd_r;
      end
      OP_DIFF: begin
        ux_r <= ext(vb_r[3*CB-1:2*CB]) - ext(va_r[3*CB-1:2*CB]);
        uy_r <= ext(vb_r[2*CB-1:CB])   - ext(va_r[2*CB-1:CB]);
        uz_r <= ext(vb_r[CB-1:0])      - ext(va_r[CB-1:0]);
        wx_r <= ext(vrd_r[3*CB-1:2*CB]) - ext(va_r[3*CB-1:2*CB]);
        wy_r <= ext(vrd_r[2*CB-1:CB])   - ext(va_r[2*CB-1:CB]);
        wz_r <= ext(vrd_r[CB-1:0])      - ext(va_r[CB-1:0]);
      end
      OP_MUL: begin
        case (cnt_r[2:0])
          3'd0:    nx_r <= prod_e;
          3'd1:    nx_r <= nx_r - prod_e;
          3'd2:    ny_r <= prod_e;
          3'd3:    ny_r <= ny_r - prod_e;
          3'd4:    nz_r <= prod_e;
          default: nz_r <= nz_r - prod_e;
        endcase
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          sgn_r[i] <= sum_c[i][SB-1];
          mag_r[i] <= sum_c[i][SB-1] ? SB'(~sum_c[i] + 1'b1) : sum_c[i];
        end
      end
      OP_ZERO:  res_st_r <= STAT_ZERO_LEN;
      OP_SHIFT: begin
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
      end
      OP_SQ: sq_r <= (cnt_r == 6'd0) ? SQ_BITS'(sq_p) : sq_r + SQ_BITS'(sq_p);
      OP_SQRT_INIT: begin
        sn_r <= 64'(sq_r);
        sr_r <= '0;
        sb_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT: begin
        if (sq_ge) begin
          sn_r <= sn_r - sq_t;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      OP_DIV_INIT: begin
        rem_r <= REM_BITS'({mag_r[idx_r][MAG_BITS-1:0], {FRAC_BITS{1'b0}}}) +
                 REM_BITS'(len >> 1);
        q_r   <= '0;
      end
      OP_DIV: begin
        rem_r <= dv_ge ? rem_r - dv : rem_r;
        q_r   <= q_nxt;
        if (cnt_r == DIV_LAST) res_n_r[idx_r] <= q_sgn;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.req       = req_r;
    sts.range_err = range_err_r;
    sts.acc_zero  = acc_zero_c;
    sts.mag_big   = mag_big_c;
    sts.out_free  = !out_valid_r || out_ready;
    sts.cnt       = cnt_r;
    sts.idx       = idx_r;
  end

  assign out_valid    = out_valid_r;
  assign out_normal_x = out_n_r[0];
  assign out_normal_y = out_n_r[1];
  assign out_normal_z = out_n_r[2];
  assign out_status   = out_st_r;

endmodule

// File: rtl/vertex_normal_accumulator_top.sv
// Top level of the area-weighted vertex normal accumulator.
// Depends on vna_pkg, the channel interfaces in vna_ifs, vna_ctrl and vna_datapath.
//
// Usage:
//  - in_ch carries requests: load a vertex (clears its sum), accumulate a triangle
//    (cross product (b-a)x(c-a) added, saturating, to all three corners), or read the
//    normalized Q1.14 normal of a slot. Every request yields one transfer on out_ch.
//  - cfg_ch writes vertex_count; it is always ready and is to be used only while idle.
//    Slots at or above vertex_count or MAX_VERTICES give status 1 and no change.
//  - One request is processed at a time; in_ch.ready is high only when the sequencer
//    is idle, so the next request is taken only after the result is registered.
//    A read first shifts the sums right until every magnitude is below 2^30
//    (up to SUM_BITS-30 shifts); an all-zero sum gives status 2 without a root.
//    The read then uses the 32-step square root and three 15-step divides
//    on one shared unit; the triangle uses one shared multiplier (six products)
//    and three read-modify-writes through the single-port sum memory.
//  - Results sit in an output register; a stalled receiver holds it, and the next
//    request is still taken and worked on until its own result needs the register.
//  - rst_n (synchronous, active low) resets the sequencer, the output valid and
//    vertex_count to 1024. Vertex and sum memories are not cleared: a slot must be
//    loaded before a triangle or read touches it.
module vertex_normal_accumulator_top import vna_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  parameter int SUM_BITS     = 44
) (
  input logic       clk,
  input logic       rst_n,
  vna_in_if.sink    in_ch,
  vna_out_if.source out_ch,
  vna_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  vna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vna_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_ch.req_type),
    .in_vertex_slot   (in_ch.vertex_slot),
    .in_pos_x         (in_ch.pos_x),
    .in_pos_y         (in_ch.pos_y),
    .in_pos_z         (in_ch.pos_z),
    .in_corner_a      (in_ch.corner_a),
    .in_corner_b      (in_ch.corner_b),
    .in_corner_c      (in_ch.corner_c),
    .cfg_we           (cfg_ch.valid),
    .cfg_vertex_count (cfg_ch.vertex_count),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_normal_x     (out_ch.normal_x),
    .out_normal_y     (out_ch.normal_y),
    .out_normal_z     (out_ch.normal_z),
    .out_status       (out_ch.status)
  );

endmodule
